>>> src/icic_pkg.sv
// ----------------------------------------------------------------------------
// icic_pkg
// Shared types and constants of the timer input capture and interrupt
// controller: command codes, register addresses, bit positions and vectors.
// ----------------------------------------------------------------------------
package icic_pkg;

  localparam logic [2:0] CMD_PIN   = 3'd0;
  localparam logic [2:0] CMD_NMI   = 3'd1;
  localparam logic [2:0] CMD_IRQ   = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_WRITE = 3'd4;
  localparam logic [2:0] CMD_CHECK = 3'd5;

  localparam logic [15:0] ADDR_TCSR   = 16'h0008;
  localparam logic [15:0] ADDR_CAP_LO = 16'h000d;
  localparam logic [15:0] ADDR_CAP_HI = 16'h000e;

  localparam int BIT_ICF  = 7;
  localparam int BIT_EICI = 4;
  localparam int BIT_IEDG = 1;

  localparam logic [7:0] TCSR_WRITABLE = 8'h1f;
  localparam logic [7:0] TCSR_KEPT     = 8'he0;

  localparam logic [15:0] VEC_IRQ1    = 16'hfff8;
  localparam logic [15:0] VEC_CAPTURE = 16'hfff6;
  localparam logic [15:0] VEC_NMI     = 16'hfffc;

  localparam logic [1:0] TAKE_NONE    = 2'd0;
  localparam logic [1:0] TAKE_NMI     = 2'd1;
  localparam logic [1:0] TAKE_IRQ1    = 2'd2;
  localparam logic [1:0] TAKE_CAPTURE = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        level;
    logic [15:0] address;
    logic [7:0]  write_byte;
    logic [15:0] counter_value;
    logic        mask_bit;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        reg_hit;
    logic [1:0]  take_kind;
    logic [15:0] vector_address;
    logic        wake;
  } result_t;

endpackage

>>> src/icic_core.sv
// ----------------------------------------------------------------------------
// icic_core
// TCSR, capture latch, line state and interrupt priority. Updates the state
// and produces one result for every word that is processed.
// ----------------------------------------------------------------------------
module icic_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  icic_pkg::item_t   item,
  output icic_pkg::result_t res
);

  logic [7:0]  tcsr_r, tcsr_nxt;
  logic [7:0]  fsr_r, fsr_nxt;
  logic [15:0] cap_r, cap_nxt;
  logic        pin_r, pin_nxt;
  logic        nmi_line_r, nmi_line_nxt;
  logic        nmi_wait_r, nmi_wait_nxt;
  logic        irq_r, irq_nxt;

  logic        hit;
  logic        do_check;
  logic [7:0]  chk_tcsr;
  logic [7:0]  tcsr_w;

  always_comb begin
    tcsr_nxt     = tcsr_r;
    fsr_nxt      = fsr_r;
    cap_nxt      = cap_r;
    pin_nxt      = pin_r;
    nmi_line_nxt = nmi_line_r;
    nmi_wait_nxt = nmi_wait_r;
    irq_nxt      = irq_r;
    res          = '0;
    do_check     = 1'b0;
    chk_tcsr     = tcsr_r;
    hit = (item.address == icic_pkg::ADDR_TCSR) ||
          (item.address == icic_pkg::ADDR_CAP_LO) ||
          (item.address == icic_pkg::ADDR_CAP_HI);
    tcsr_w = (item.write_byte & icic_pkg::TCSR_WRITABLE) |
             (tcsr_r & icic_pkg::TCSR_KEPT);

    case (item.cmd)
      icic_pkg::CMD_PIN: begin
        if (item.level != pin_r) begin
          pin_nxt = item.level;
          // capture edge follows IEDG: rising when set, falling when clear
          if (item.level == tcsr_r[icic_pkg::BIT_IEDG]) begin
            tcsr_nxt[icic_pkg::BIT_ICF] = 1'b1;
            fsr_nxt[icic_pkg::BIT_ICF]  = 1'b1;
            cap_nxt = item.counter_value;
          end
        end
      end
      icic_pkg::CMD_NMI: begin
        if (!nmi_line_r && item.level) begin
          nmi_wait_nxt = 1'b1;
        end
        nmi_line_nxt = item.level;
      end
      icic_pkg::CMD_IRQ: begin
        irq_nxt = item.level;
      end
      icic_pkg::CMD_READ: begin
        if (hit) begin
          res.reg_hit = 1'b1;
          if (item.address == icic_pkg::ADDR_TCSR) begin
            fsr_nxt       = '0;
            res.read_byte = tcsr_r;
          end else if (item.address == icic_pkg::ADDR_CAP_LO) begin
            // flag raised since the last status read survives this read
            if (!fsr_r[icic_pkg::BIT_ICF]) begin
              tcsr_nxt[icic_pkg::BIT_ICF] = 1'b0;
            end
            res.read_byte = cap_r[7:0];
          end else begin
            res.read_byte = cap_r[15:8];
          end
        end
      end
      icic_pkg::CMD_WRITE: begin
        if (hit) begin
          res.reg_hit = 1'b1;
          if (item.address == icic_pkg::ADDR_TCSR) begin
            tcsr_nxt = tcsr_w;
            fsr_nxt  = fsr_r & tcsr_w;
            chk_tcsr = tcsr_w;
            do_check = 1'b1;
          end
        end
      end
      icic_pkg::CMD_CHECK: begin
        do_check = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_check) begin
      if (nmi_wait_r) begin
        nmi_wait_nxt       = 1'b0;
        res.take_kind      = icic_pkg::TAKE_NMI;
        res.vector_address = icic_pkg::VEC_NMI;
        res.wake           = 1'b1;
      end else if (irq_r) begin
        res.wake = 1'b1;
        if (!item.mask_bit) begin
          res.take_kind      = icic_pkg::TAKE_IRQ1;
          res.vector_address = icic_pkg::VEC_IRQ1;
        end
      end else if (chk_tcsr[icic_pkg::BIT_EICI] && chk_tcsr[icic_pkg::BIT_ICF]) begin
        res.wake = 1'b1;
        if (!item.mask_bit) begin
          res.take_kind      = icic_pkg::TAKE_CAPTURE;
          res.vector_address = icic_pkg::VEC_CAPTURE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcsr_r     <= '0;
      fsr_r      <= '0;
      cap_r      <= '0;
      pin_r      <= 1'b0;
      nmi_line_r <= 1'b0;
      nmi_wait_r <= 1'b0;
      irq_r      <= 1'b0;
    end else if (fire) begin
      tcsr_r     <= tcsr_nxt;
      fsr_r      <= fsr_nxt;
      cap_r      <= cap_nxt;
      pin_r      <= pin_nxt;
      nmi_line_r <= nmi_line_nxt;
      nmi_wait_r <= nmi_wait_nxt;
      irq_r      <= irq_nxt;
    end
  end

endmodule

>>> src/input_capture_interrupt_ctrl.sv
// ----------------------------------------------------------------------------
// input_capture_interrupt_ctrl
// Timer control/status register, input capture latch and interrupt priority
// logic with an input register and a result register around it.
// ----------------------------------------------------------------------------
// Each word (pin, NMI or IRQ1 level, register read or write, interrupt check)
// passes an input register, update logic on the status state and a result
// register. The result register loads when the held word is processed, which
// can wait while an untaken result blocks it; the result is then offered on
// out_valid until taken. A new word is taken every cycle while results are
// drained. Priority is NMI, then IRQ1, then input capture; a status write also
// runs the check. Status, capture, line state and valid flags clear on reset.
module input_capture_interrupt_ctrl (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic        in_level,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_byte,
  input  logic [15:0] in_counter_value,
  input  logic        in_mask_bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_byte,
  output logic        out_reg_hit,
  output logic [1:0]  out_take_kind,
  output logic [15:0] out_vector_address,
  output logic        out_wake
);

  icic_pkg::item_t   item_r;
  logic              item_valid_r;
  icic_pkg::result_t res;
  icic_pkg::result_t res_r;
  logic              res_valid_r;
  logic              fire;
  logic              in_fire;

  assign fire     = item_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !item_valid_r || fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        item_valid_r <= 1'b1;
      end else if (fire) begin
        item_valid_r <= 1'b0;
      end
      if (fire) begin
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.cmd           <= in_cmd;
      item_r.level         <= in_level;
      item_r.address       <= in_address;
      item_r.write_byte    <= in_write_byte;
      item_r.counter_value <= in_counter_value;
      item_r.mask_bit      <= in_mask_bit;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  icic_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .res   (res)
  );

  assign out_valid          = res_valid_r;
  assign out_read_byte      = res_r.read_byte;
  assign out_reg_hit        = res_r.reg_hit;
  assign out_take_kind      = res_r.take_kind;
  assign out_vector_address = res_r.vector_address;
  assign out_wake           = res_r.wake;

endmodule

>>> dv/icic_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icic_checker
// Watches both channels of the input capture and interrupt controller, keeps
// its own copy of the status, capture and line state, predicts the result of
// every accepted word and compares each returned result field by field.
// ----------------------------------------------------------------------------
module icic_checker
  import icic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic        in_level,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_byte,
  input  logic [15:0] in_counter_value,
  input  logic        in_mask_bit,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_read_byte,
  input  logic        out_reg_hit,
  input  logic [1:0]  out_take_kind,
  input  logic [15:0] out_vector_address,
  input  logic        out_wake,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          taken_nmi,
  output int          taken_irq1,
  output int          taken_capture
);

  localparam int MAX_PRINTS = 40;

  logic [7:0]  tcsr_q;
  logic [7:0]  tcsr_fresh;
  logic [15:0] capture_q;
  logic        pin_q;
  logic        nmi_line_q;
  logic        nmi_latched_q;
  logic        irq_line_q;

  result_t awaited_q[$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked       = 0;
    taken_nmi     = 0;
    taken_irq1    = 0;
    taken_capture = 0;
  end

  task automatic log_mismatch(input string what);
    if (fail_count < MAX_PRINTS) begin
      $display("%0t: result %0d mismatch: %s", $time, checked, what);
    end
    fail_count++;
  endtask

  // priority: nmi, then irq1 (a masked irq1 still hides capture), then capture
  task automatic arbitrate(input logic masked, inout result_t r);
    if (nmi_latched_q) begin
      nmi_latched_q    = 1'b0;
      r.take_kind      = TAKE_NMI;
      r.vector_address = VEC_NMI;
      r.wake           = 1'b1;
      taken_nmi++;
    end else if (irq_line_q) begin
      r.wake = 1'b1;
      if (!masked) begin
        r.take_kind      = TAKE_IRQ1;
        r.vector_address = VEC_IRQ1;
        taken_irq1++;
      end
    end else if (tcsr_q[BIT_EICI] && tcsr_q[BIT_ICF]) begin
      r.wake = 1'b1;
      if (!masked) begin
        r.take_kind      = TAKE_CAPTURE;
        r.vector_address = VEC_CAPTURE;
        taken_capture++;
      end
    end
  endtask

  task automatic apply_event(input item_t w, output result_t r);
    logic hit;
    r   = '0;
    hit = (w.address == ADDR_TCSR) || (w.address == ADDR_CAP_LO) ||
          (w.address == ADDR_CAP_HI);
    case (w.cmd)
      CMD_PIN: begin
        if (w.level != pin_q) begin
          pin_q = w.level;
          // iedg high selects the rising edge
          if (w.level == tcsr_q[BIT_IEDG]) begin
            tcsr_q[BIT_ICF]     = 1'b1;
            tcsr_fresh[BIT_ICF] = 1'b1;
            capture_q           = w.counter_value;
          end
        end
      end
      CMD_NMI: begin
        if (!nmi_line_q && w.level) nmi_latched_q = 1'b1;
        nmi_line_q = w.level;
      end
      CMD_IRQ: irq_line_q = w.level;
      CMD_READ: begin
        if (hit) begin
          r.reg_hit = 1'b1;
          if (w.address == ADDR_TCSR) begin
            tcsr_fresh  = '0;
            r.read_byte = tcsr_q;
          end else if (w.address == ADDR_CAP_LO) begin
            // icf survives if it rose after the last status read
            if (!tcsr_fresh[BIT_ICF]) tcsr_q[BIT_ICF] = 1'b0;
            r.read_byte = capture_q[7:0];
          end else begin
            r.read_byte = capture_q[15:8];
          end
        end
      end
      CMD_WRITE: begin
        if (hit) begin
          r.reg_hit = 1'b1;
          if (w.address == ADDR_TCSR) begin
            tcsr_q     = (w.write_byte & TCSR_WRITABLE) | (tcsr_q & TCSR_KEPT);
            tcsr_fresh = tcsr_fresh & tcsr_q;
            arbitrate(w.mask_bit, r);
          end
        end
      end
      CMD_CHECK: arbitrate(w.mask_bit, r);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    item_t   w;
    result_t want;
    result_t got;
    if (!rst_n) begin
      tcsr_q        = '0;
      tcsr_fresh    = '0;
      capture_q     = '0;
      pin_q         = 1'b0;
      nmi_line_q    = 1'b0;
      nmi_latched_q = 1'b0;
      irq_line_q    = 1'b0;
      awaited_q.delete();
    end else begin
      // a result can never belong to the word taken on this same edge
      if (out_valid && out_ready) begin
        got = '{out_read_byte, out_reg_hit, out_take_kind, out_vector_address, out_wake};
        if (awaited_q.size() == 0) begin
          log_mismatch("result with no word outstanding");
        end else begin
          want = awaited_q.pop_front();
          if (got.read_byte !== want.read_byte)
            log_mismatch($sformatf("read_byte %h, want %h", got.read_byte, want.read_byte));
          if (got.reg_hit !== want.reg_hit)
            log_mismatch($sformatf("reg_hit %b, want %b", got.reg_hit, want.reg_hit));
          if (got.take_kind !== want.take_kind)
            log_mismatch($sformatf("take_kind %0d, want %0d", got.take_kind, want.take_kind));
          if (got.vector_address !== want.vector_address)
            log_mismatch($sformatf("vector_address %h, want %h",
                                   got.vector_address, want.vector_address));
          if (got.wake !== want.wake)
            log_mismatch($sformatf("wake %b, want %b", got.wake, want.wake));
        end
        checked++;
      end
      if (in_valid && in_ready) begin
        w = '{in_cmd, in_level, in_address, in_write_byte, in_counter_value, in_mask_bit};
        apply_event(w, want);
        awaited_q.push_back(want);
      end
    end
    pending = awaited_q.size();
  end

endmodule

>>> dv/tb_input_capture_interrupt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_input_capture_interrupt_ctrl
// Drives status, capture and interrupt line words into the controller: a
// directed pass over edges, flag clearing and priority, then random words
// under three idle mixes. Checking is done by icic_checker.
// ----------------------------------------------------------------------------
module tb_input_capture_interrupt_ctrl;
  import icic_pkg::*;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_WORDS  = 445;
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [2:0]  in_cmd           = '0;
  logic        in_level         = 1'b0;
  logic [15:0] in_address       = '0;
  logic [7:0]  in_write_byte    = '0;
  logic [15:0] in_counter_value = '0;
  logic        in_mask_bit      = 1'b0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [7:0]  out_read_byte;
  logic        out_reg_hit;
  logic [1:0]  out_take_kind;
  logic [15:0] out_vector_address;
  logic        out_wake;

  int   fail_count;
  int   pending;
  int   checked;
  int   taken_nmi;
  int   taken_irq1;
  int   taken_capture;
  int   in_idle_pct  = 0;
  int   out_idle_pct = 0;
  logic steady       = 1'b0;
  int   words_sent   = 0;
  int   stall_cycles = 0;

  input_capture_interrupt_ctrl dut (.*);

  icic_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_input_capture_interrupt_ctrl: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic item_t mk(input logic [2:0] c, input logic lv, input logic [15:0] a,
                               input logic [7:0] d, input logic [15:0] cnt,
                               input logic m);
    item_t w;
    w = '{c, lv, a, d, cnt, m};
    return w;
  endfunction

  function automatic logic [15:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return ADDR_TCSR;
    if (r < 55) return ADDR_CAP_LO;
    if (r < 75) return ADDR_CAP_HI;
    if (r < 85) return 16'($urandom_range(7, 15));
    return 16'($urandom);
  endfunction

  function automatic item_t pick_word();
    item_t w;
    int    r;
    w = mk(CMD_CHECK, 1'($urandom), pick_address(), 8'($urandom), 16'($urandom),
           1'($urandom));
    r = $urandom_range(0, 99);
    if (r < 20)      w.cmd = CMD_PIN;
    else if (r < 28) w.cmd = CMD_NMI;
    else if (r < 36) w.cmd = CMD_IRQ;
    else if (r < 56) w.cmd = CMD_READ;
    else if (r < 76) w.cmd = CMD_WRITE;
    else if (r < 97) w.cmd = CMD_CHECK;
    else if (r < 98) w.cmd = CMD_SPARE_A;
    else             w.cmd = CMD_SPARE_B;
    // keep irq1 mostly low so capture requests get a chance
    if (w.cmd == CMD_IRQ) w.level = ($urandom_range(0, 99) < 30);
    return w;
  endfunction

  task automatic send_word(input item_t w);
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= w.cmd;
    in_level         <= w.level;
    in_address       <= w.address;
    in_write_byte    <= w.write_byte;
    in_counter_value <= w.counter_value;
    in_mask_bit      <= w.mask_bit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int n_words, input int send_idle, input int recv_idle);
    int    done;
    int    next_block;
    int    r;
    item_t w;
    done         = 0;
    next_block   = 0;
    in_idle_pct  = send_idle;
    out_idle_pct = recv_idle;
    while (done < n_words) begin
      if (done >= next_block) begin
        steady     <= ($urandom_range(0, 3) == 0);
        next_block += 32;
      end
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // typical service routine: status, then capture low and high
        w = pick_word();
        w.cmd = CMD_READ;
        w.address = ADDR_TCSR;
        send_word(w);
        w.address = ADDR_CAP_LO;
        send_word(w);
        w.address = ADDR_CAP_HI;
        send_word(w);
        done += 3;
      end else if (r < 22) begin
        // arm capture, move the pin, then look for the request
        w = pick_word();
        w.cmd = CMD_WRITE;
        w.address = ADDR_TCSR;
        w.write_byte[BIT_EICI] = 1'b1;
        send_word(w);
        w = pick_word();
        w.cmd = CMD_PIN;
        send_word(w);
        w = pick_word();
        w.cmd = CMD_CHECK;
        send_word(w);
        done += 3;
      end else begin
        send_word(pick_word());
        done++;
      end
    end
  endtask

  initial begin
    in_idle_pct  = 26;
    out_idle_pct = 60;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: edges, flag clearing, masking and priority
    send_word(mk(CMD_CHECK, 1'b0, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_READ,  1'b1, ADDR_TCSR, 8'hff, 16'hffff, 1'b1));
    send_word(mk(CMD_WRITE, 1'b0, ADDR_TCSR, 8'hff, 16'h0000, 1'b0));
    send_word(mk(CMD_PIN,   1'b1, 16'hffff, 8'h00, 16'hffff, 1'b0));
    send_word(mk(CMD_PIN,   1'b1, 16'h0000, 8'h00, 16'h1234, 1'b0));
    send_word(mk(CMD_CHECK, 1'b0, 16'h0000, 8'h00, 16'h0000, 1'b1));
    send_word(mk(CMD_CHECK, 1'b0, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_READ,  1'b0, ADDR_CAP_LO, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_READ,  1'b0, ADDR_CAP_HI, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_READ,  1'b0, ADDR_TCSR, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_READ,  1'b0, ADDR_CAP_LO, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_WRITE, 1'b0, ADDR_TCSR, 8'h10, 16'h0000, 1'b1));
    send_word(mk(CMD_PIN,   1'b0, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_WRITE, 1'b0, ADDR_CAP_LO, 8'haa, 16'h0000, 1'b0));
    send_word(mk(CMD_WRITE, 1'b0, 16'hffff, 8'h55, 16'h0000, 1'b0));
    send_word(mk(CMD_READ,  1'b0, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_IRQ,   1'b1, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_CHECK, 1'b0, 16'h0000, 8'h00, 16'h0000, 1'b1));
    send_word(mk(CMD_CHECK, 1'b0, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_NMI,   1'b1, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_NMI,   1'b1, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_WRITE, 1'b0, ADDR_TCSR, 8'he0, 16'h0000, 1'b1));
    send_word(mk(CMD_IRQ,   1'b0, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_CHECK, 1'b0, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_word(mk(CMD_SPARE_A, 1'b1, ADDR_TCSR, 8'hff, 16'hffff, 1'b1));
    send_word(mk(CMD_SPARE_B, 1'b1, ADDR_CAP_LO, 8'hff, 16'hffff, 1'b1));

    run_phase(PHASE_WORDS, 26, 60);
    wait_drained();
    run_phase(PHASE_WORDS, 60, 26);
    run_phase(PHASE_WORDS, 0, 0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d words (directed, idle mixes, back to back); %0d results checked",
             words_sent, checked);
    $display("interrupts taken: nmi %0d, irq1 %0d, capture %0d",
             taken_nmi, taken_irq1, taken_capture);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_input_capture_interrupt_ctrl: PASS");
    end else begin
      $display("tb_input_capture_interrupt_ctrl: FAIL");
    end
    $finish;
  end

endmodule
